### sv/json_byte_tokenizer_assert.svh
// Assertion macros for the JSON byte tokenizer.
// Needs signals named clock and reset in the module that uses them.
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JBT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jbt assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define JBT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jbt assertion failed");

`endif

### sv/jbt_pkg.sv
// Shared types, codes and keyword tables for the JSON byte tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package jbt_pkg;

   // Lexer modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STR,
      MODE_ESC,
      MODE_HEX,
      MODE_KEY,
      MODE_NUM
   } mode_type;

   // Token kinds
   localparam logic [3:0] KIND_LBRACE   = 4'd0;
   localparam logic [3:0] KIND_RBRACE   = 4'd1;
   localparam logic [3:0] KIND_LBRACKET = 4'd2;
   localparam logic [3:0] KIND_RBRACKET = 4'd3;
   localparam logic [3:0] KIND_COLON    = 4'd4;
   localparam logic [3:0] KIND_COMMA    = 4'd5;
   localparam logic [3:0] KIND_STRSTART = 4'd6;
   localparam logic [3:0] KIND_STRBYTE  = 4'd7;
   localparam logic [3:0] KIND_STREND   = 4'd8;
   localparam logic [3:0] KIND_NUMBYTE  = 4'd9;
   localparam logic [3:0] KIND_NUMEND   = 4'd10;
   localparam logic [3:0] KIND_TRUE     = 4'd11;
   localparam logic [3:0] KIND_FALSE    = 4'd12;
   localparam logic [3:0] KIND_NULL     = 4'd13;
   localparam logic [3:0] KIND_END      = 4'd14;
   localparam logic [3:0] KIND_ERROR    = 4'd15;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
   localparam logic [2:0] ERR_KEYWORD    = 3'd2;
   localparam logic [2:0] ERR_UNTERM     = 3'd3;
   localparam logic [2:0] ERR_ESC_NUM    = 3'd4;

   // Number phases
   localparam logic [2:0] NUM_SIGN   = 3'd0;
   localparam logic [2:0] NUM_INT    = 3'd1;
   localparam logic [2:0] NUM_FRAC   = 3'd2;
   localparam logic [2:0] NUM_EXP    = 3'd3;
   localparam logic [2:0] NUM_EXPDIG = 3'd4;

   // Keyword selectors
   localparam logic [1:0] KW_TRUE  = 2'd0;
   localparam logic [1:0] KW_FALSE = 2'd1;
   localparam logic [1:0] KW_NULL  = 2'd2;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] tbyte;
      logic [2:0] err;
   } token_type;

   typedef struct packed {
      token_type  tok;
      logic       last;
   } entry_type;

   // Letter idx of keyword sel; zero past the end
   function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      case (sel)
         KW_TRUE: begin
            case (idx)
               3'd0: ch = 8'h74;  // t
               3'd1: ch = 8'h72;  // r
               3'd2: ch = 8'h75;  // u
               3'd3: ch = 8'h65;  // e
               default: ch = 8'h00;
            endcase
         end
         KW_FALSE: begin
            case (idx)
               3'd0: ch = 8'h66;  // f
               3'd1: ch = 8'h61;  // a
               3'd2: ch = 8'h6C;  // l
               3'd3: ch = 8'h73;  // s
               3'd4: ch = 8'h65;  // e
               default: ch = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               3'd0: ch = 8'h6E;  // n
               3'd1: ch = 8'h75;  // u
               3'd2: ch = 8'h6C;  // l
               3'd3: ch = 8'h6C;  // l
               default: ch = 8'h00;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] sel);
      return (sel == KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [3:0] kw_kind(input logic [1:0] sel);
      logic [3:0] k;
      case (sel)
         KW_TRUE:  k = KIND_TRUE;
         KW_FALSE: k = KIND_FALSE;
         default:  k = KIND_NULL;
      endcase
      return k;
   endfunction

   // {valid, nibble} for a hex character
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

### sv/json_byte_tokenizer.sv
// JSON byte tokenizer: lexer state, token decode and result queue.
// Depends on jbt_pkg and json_byte_tokenizer_assert.svh.
`timescale 1ns / 1ps

// Usage
// req channel: one word per text byte. req_tdata[7:0] is the byte, req_tlast
//   set marks end of text (the byte is then ignored).
// rsp channel: one word per token. rsp_tuser is the token kind, rsp_tdata
//   carries the decoded byte and error code, rsp_tlast flags the last token
//   caused by one input word. A byte gives zero, one or two tokens.
// Order: tokens from a byte enter the queue when it is accepted and leave after
//   any tokens already waiting; a second token from the same byte follows the first.
// Throughput: one byte per cycle while req_tready is high. Decode is one pass
//   of mode logic on the accepted byte; the limit is the single output port,
//   so bytes that give two tokens need an output slot for each.
// Stalls: tokens collect in a 4-word queue. req_tready stays high while the
//   queue has room for two tokens, so a stalled receiver throttles the input
//   once three or more words wait; the queue never holds more than four.
// Reset: synchronous, active high. Empties the queue and returns the lexer
//   to idle with no error latched. An end-of-text word does the same to the
//   lexer after emitting any closing token and the end token.
// The first error latches; bytes after it give no tokens until end of text.

module json_byte_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_byte, [10:8] error_code, rest zero
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);
   import jbt_pkg::*;

   // Lexer state
   mode_type   mode_ff, mode_in;
   logic [1:0] kw_sel_ff, kw_sel_in;
   logic [2:0] kw_idx_ff, kw_idx_in;
   logic [7:0] hex_ff, hex_in;          // low byte of the \u value
   logic [1:0] hex_cnt_ff, hex_cnt_in;
   logic [2:0] num_phase_ff, num_phase_in;
   logic       num_digit_ff, num_digit_in;
   logic       err_ff, err_in;

   // Result queue
   entry_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   logic       req_acc, rsp_pop;
   logic [7:0] c;

   // Start-of-token decode
   token_type  st_tok;
   logic       st_emit, st_fail;
   mode_type   st_mode;
   logic [1:0] st_kw_sel;
   logic [2:0] st_phase;
   logic       st_digit;

   // Number continuation
   logic       is_dig, is_exp, num_take;
   logic [2:0] nt_phase;
   logic       nt_digit;

   // Keyword match
   logic [1:0] kw_s;
   logic [2:0] kw_next;

   logic [4:0] hex_d;

   // Tokens for this byte
   token_type  t0, t1;
   logic [1:0] tok_n;
   entry_type  e0, e1;

   assign c       = req_tdata;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_pop = rsp_tvalid && rsp_tready;

   // Character classes
   assign is_dig = (c >= 8'h30) && (c <= 8'h39);
   assign is_exp = (c == 8'h65) || (c == 8'h45);
   assign hex_d  = hex_nibble(c);
   assign kw_s   = (kw_sel_ff > KW_NULL) ? KW_NULL : kw_sel_ff;
   assign kw_next = kw_idx_ff + 3'd1;

   // What a byte does when it opens a token
   always_comb begin
      st_tok    = '{kind: KIND_LBRACE, tbyte: 8'h00, err: ERR_NONE};
      st_emit   = 1'b0;
      st_fail   = 1'b0;
      st_mode   = MODE_IDLE;
      st_kw_sel = kw_sel_ff;
      st_phase  = num_phase_ff;
      st_digit  = num_digit_ff;
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
            // whitespace: nothing
         end
         8'h7B: begin st_emit = 1'b1; st_tok.kind = KIND_LBRACE;   end
         8'h7D: begin st_emit = 1'b1; st_tok.kind = KIND_RBRACE;   end
         8'h5B: begin st_emit = 1'b1; st_tok.kind = KIND_LBRACKET; end
         8'h5D: begin st_emit = 1'b1; st_tok.kind = KIND_RBRACKET; end
         8'h3A: begin st_emit = 1'b1; st_tok.kind = KIND_COLON;    end
         8'h2C: begin st_emit = 1'b1; st_tok.kind = KIND_COMMA;    end
         8'h22: begin
            st_emit     = 1'b1;
            st_tok.kind = KIND_STRSTART;
            st_mode     = MODE_STR;
         end
         8'h74: begin st_kw_sel = KW_TRUE;  st_mode = MODE_KEY; end
         8'h66: begin st_kw_sel = KW_FALSE; st_mode = MODE_KEY; end
         8'h6E: begin st_kw_sel = KW_NULL;  st_mode = MODE_KEY; end
         default: begin
            st_emit = 1'b1;
            if (c == 8'h2D || is_dig) begin
               st_tok.kind  = KIND_NUMBYTE;
               st_tok.tbyte = c;
               st_mode      = MODE_NUM;
               st_phase     = is_dig ? NUM_INT : NUM_SIGN;
               st_digit     = is_dig;
            end else begin
               st_fail      = 1'b1;
               st_tok.kind  = KIND_ERROR;
               st_tok.err   = ERR_UNEXPECTED;
            end
         end
      endcase
   end

   // Does the byte continue the open number
   always_comb begin
      num_take = 1'b0;
      nt_phase = num_phase_ff;
      nt_digit = num_digit_ff;
      case (num_phase_ff)
         NUM_SIGN, NUM_INT: begin
            if (is_dig) begin
               num_take = 1'b1; nt_phase = NUM_INT; nt_digit = 1'b1;
            end else if (c == 8'h2E) begin
               num_take = 1'b1; nt_phase = NUM_FRAC;
            end else if (is_exp) begin
               num_take = 1'b1; nt_phase = NUM_EXP;
            end
         end
         NUM_FRAC: begin
            if (is_dig) begin
               num_take = 1'b1; nt_digit = 1'b1;
            end else if (is_exp) begin
               num_take = 1'b1; nt_phase = NUM_EXP;
            end
         end
         NUM_EXP: begin
            if (is_dig || c == 8'h2B || c == 8'h2D) begin
               num_take = 1'b1; nt_phase = NUM_EXPDIG;
            end
         end
         default: num_take = is_dig;
      endcase
   end

   // Main step: tokens and next lexer state for the word on req
   always_comb begin
      t0           = '{kind: KIND_ERROR, tbyte: 8'h00, err: ERR_NONE};
      t1           = '{kind: KIND_ERROR, tbyte: 8'h00, err: ERR_NONE};
      tok_n        = 2'd0;
      mode_in      = mode_ff;
      kw_sel_in    = kw_sel_ff;
      kw_idx_in    = kw_idx_ff;
      hex_in       = hex_ff;
      hex_cnt_in   = hex_cnt_ff;
      num_phase_in = num_phase_ff;
      num_digit_in = num_digit_ff;
      err_in       = err_ff;

      if (req_tlast) begin
         // closing token for whatever is open, then end
         t1.kind = KIND_END;
         t1.err  = ERR_NONE;
         tok_n   = 2'd1;
         if (!err_ff) begin
            case (mode_ff)
               MODE_KEY: begin tok_n = 2'd2; t0.err = ERR_KEYWORD; end
               MODE_STR, MODE_ESC: begin tok_n = 2'd2; t0.err = ERR_UNTERM; end
               MODE_HEX: begin tok_n = 2'd2; t0.err = ERR_ESC_NUM; end
               MODE_NUM: begin
                  tok_n = 2'd2;
                  if (num_digit_ff) t0.kind = KIND_NUMEND;
                  else              t0.err  = ERR_ESC_NUM;
               end
               default: tok_n = 2'd1;
            endcase
         end
         if (tok_n == 2'd1) t0 = t1;
         mode_in      = MODE_IDLE;
         kw_sel_in    = KW_TRUE;
         kw_idx_in    = 3'd0;
         hex_in       = 8'h00;
         hex_cnt_in   = 2'd0;
         num_phase_in = NUM_SIGN;
         num_digit_in = 1'b0;
         err_in       = 1'b0;
      end else if (!err_ff) begin
         case (mode_ff)
            MODE_STR: begin
               if (c == 8'h22) begin
                  tok_n   = 2'd1;
                  t0.kind = KIND_STREND;
                  mode_in = MODE_IDLE;
               end else if (c == 8'h5C) begin
                  mode_in = MODE_ESC;
               end else begin
                  tok_n    = 2'd1;
                  t0.kind  = KIND_STRBYTE;
                  t0.tbyte = c;
               end
            end
            MODE_ESC: begin
               if (c == 8'h75) begin
                  hex_in     = 8'h00;
                  hex_cnt_in = 2'd0;
                  mode_in    = MODE_HEX;
               end else begin
                  tok_n   = 2'd1;
                  t0.kind = KIND_STRBYTE;
                  mode_in = MODE_STR;
                  case (c)
                     8'h62:   t0.tbyte = 8'h08;   // \b
                     8'h66:   t0.tbyte = 8'h0C;   // \f
                     8'h6E:   t0.tbyte = 8'h0A;   // \n
                     8'h72:   t0.tbyte = 8'h0D;   // \r
                     8'h74:   t0.tbyte = 8'h09;   // \t
                     default: t0.tbyte = c;       // unknown escapes pass through
                  endcase
               end
            end
            MODE_HEX: begin
               if (!hex_d[4]) begin
                  tok_n   = 2'd1;
                  t0.err  = ERR_ESC_NUM;
                  err_in  = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  // only the low byte of the code point is kept
                  hex_in     = {hex_ff[3:0], hex_d[3:0]};
                  hex_cnt_in = hex_cnt_ff + 2'd1;
                  if (hex_cnt_ff == 2'd3) begin
                     tok_n      = 2'd1;
                     t0.kind    = KIND_STRBYTE;
                     t0.tbyte   = {hex_ff[3:0], hex_d[3:0]};
                     hex_cnt_in = 2'd0;
                     mode_in    = MODE_STR;
                  end
               end
            end
            MODE_KEY: begin
               if (kw_idx_ff >= kw_len(kw_s) || c != kw_char(kw_s, kw_idx_ff)) begin
                  tok_n   = 2'd1;
                  t0.err  = ERR_KEYWORD;
                  err_in  = 1'b1;
                  mode_in = MODE_IDLE;
               end else if (kw_next >= kw_len(kw_s)) begin
                  tok_n     = 2'd1;
                  t0.kind   = kw_kind(kw_s);
                  kw_idx_in = 3'd0;
                  mode_in   = MODE_IDLE;
               end else begin
                  kw_idx_in = kw_next;
               end
            end
            MODE_NUM: begin
               if (num_take) begin
                  tok_n        = 2'd1;
                  t0.kind      = KIND_NUMBYTE;
                  t0.tbyte     = c;
                  num_phase_in = nt_phase;
                  num_digit_in = nt_digit;
               end else if (!num_digit_ff) begin
                  // no mantissa digit: error, closing byte swallowed
                  tok_n   = 2'd1;
                  t0.err  = ERR_ESC_NUM;
                  err_in  = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  t0.kind = KIND_NUMEND;
                  tok_n   = st_emit ? 2'd2 : 2'd1;
                  t1      = st_tok;
                  mode_in = st_mode;
                  err_in  = st_fail;
                  if (st_mode == MODE_KEY) begin
                     kw_sel_in = st_kw_sel;
                     kw_idx_in = 3'd1;
                  end
                  num_phase_in = st_phase;
                  num_digit_in = st_digit;
               end
            end
            default: begin
               tok_n   = st_emit ? 2'd1 : 2'd0;
               t0      = st_tok;
               mode_in = st_mode;
               err_in  = st_fail;
               if (st_mode == MODE_KEY) begin
                  kw_sel_in = st_kw_sel;
                  kw_idx_in = 3'd1;
               end
               num_phase_in = st_phase;
               num_digit_in = st_digit;
            end
         endcase
      end
   end

   assign e0 = '{tok: t0, last: (tok_n == 2'd1)};
   assign e1 = '{tok: t1, last: 1'b1};

   // Queue bookkeeping
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);
   assign wr_ptr_in   = req_acc ? (wr_ptr_ff + QPTR_W'(tok_n)) : wr_ptr_ff;
   assign rd_ptr_in   = rsp_pop ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
   assign count_in    = count_ff + (req_acc ? QCNT_W'(tok_n) : QCNT_W'(0))
                        - QCNT_W'(rsp_pop);

   // room for two tokens before taking a byte
   assign req_tready = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign rsp_tvalid = (count_ff != QCNT_W'(0));
   assign rsp_tdata  = {5'b0, q_ff[rd_ptr_ff].tok.err, q_ff[rd_ptr_ff].tok.tbyte};
   assign rsp_tuser  = q_ff[rd_ptr_ff].tok.kind;
   assign rsp_tlast  = q_ff[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         kw_sel_ff    <= KW_TRUE;
         kw_idx_ff    <= 3'd0;
         hex_ff       <= 8'h00;
         hex_cnt_ff   <= 2'd0;
         num_phase_ff <= NUM_SIGN;
         num_digit_ff <= 1'b0;
         err_ff       <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (req_acc) begin
            mode_ff      <= mode_in;
            kw_sel_ff    <= kw_sel_in;
            kw_idx_ff    <= kw_idx_in;
            hex_ff       <= hex_in;
            hex_cnt_ff   <= hex_cnt_in;
            num_phase_ff <= num_phase_in;
            num_digit_ff <= num_digit_in;
            err_ff       <= err_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset
   always_ff @(posedge clock) begin
      if (req_acc) begin
         if (tok_n != 2'd0) q_ff[wr_ptr_ff] <= e0;
         if (tok_n == 2'd2) q_ff[wr_ptr_next] <= e1;
      end
   end

`include "json_byte_tokenizer_assert.svh"

   `JBT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `JBT_ASSERT_NOW(a_err_swallows, req_acc && !req_tlast && err_ff, tok_n == 2'd0)
   `JBT_ASSERT_NOW(a_end_token_last, req_acc && req_tlast, t1.kind == KIND_END && tok_n != 2'd0)
   `JBT_ASSERT_NEXT(a_end_clears, req_acc && req_tlast, mode_ff == MODE_IDLE && !err_ff && count_ff != QCNT_W'(0))
   `JBT_ASSERT_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready, count_ff >= $past(count_ff))

endmodule

### bench/json_byte_tokenizer_test.sv
// Self-checking bench for json_byte_tokenizer: a directed table, then random JSON text,
// with tokens scored against pinned expectations or a lexer model kept inside the bench.
// Depends on jbt_pkg and the json_byte_tokenizer RTL.
`timescale 1ns / 1ps

module json_byte_tokenizer_test;
   import jbt_pkg::*;

   localparam int HOLD_RESET   = 7;
   localparam int WORDS_PHASE  = 667;      // minimum words per idling phase, three phases
   localparam int DRAIN_CYCLES = 16;       // idle clocks after the last expected token
   localparam int RUN_LIMIT_NS = 5_000_000;

   // one token as the rsp channel carries it (byte zero unless strbyte/numbyte)
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] tbyte;
      logic [2:0] err;
   } tok_rec_type;

   typedef struct packed {
      tok_rec_type tok;
      logic        last;
   } pending_type;

   // directed row: pinned rows carry their tokens, the rest take the model's
   typedef struct packed {
      logic [7:0]  text;
      logic        eot;
      logic        pinned;
      logic [1:0]  count;
      tok_rec_type tok0;
      tok_rec_type tok1;
   } probe_type;

   localparam logic [7:0] WS_CHARS [0:5] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] in_byte
   logic        req_tlast = 1'b0;     // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] token_byte, [10:8] error_code, [15:11] zero
   logic [3:0]  rsp_tuser;            // [3:0] token_kind
   logic        rsp_tlast;            // last_of_run

   json_byte_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Lexer model: own copy of the tokenizer state
   // ---------------------------------------------------------------------
   mode_type    lex_mode = MODE_IDLE;
   logic [1:0]  kw_sel = KW_TRUE;
   logic [2:0]  kw_idx = 3'd0;
   logic [15:0] hex_acc = 16'h0000;
   logic [2:0]  hex_cnt = 3'd0;
   logic [2:0]  num_phase = NUM_SIGN;
   logic        num_digit = 1'b0;
   logic        err_latched = 1'b0;
   string       kw_words [3] = '{"true", "false", "null"};

   tok_rec_type step_tok [2];   // tokens caused by the word just accepted
   int          step_cnt;

   pending_type token_queue [$];
   pending_type want;
   int          fail_count = 0;
   int          live_words = 0;  // words sent in the random part
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic [7:0]  doc_text [$];

   function automatic void emit(input logic [3:0] k, input logic [7:0] b, input logic [2:0] r);
      step_tok[step_cnt] = '{kind: k, tbyte: b, err: r};
      step_cnt++;
   endfunction

   function automatic void raise_error(input logic [2:0] r);
      emit(KIND_ERROR, 8'h00, r);
      err_latched = 1'b1;
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void clear_lexer();
      lex_mode = MODE_IDLE;
      kw_sel = KW_TRUE;
      kw_idx = 3'd0;
      hex_acc = 16'h0000;
      hex_cnt = 3'd0;
      num_phase = NUM_SIGN;
      num_digit = 1'b0;
      err_latched = 1'b0;
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // nibble value of a hex character, -1 if it is not one
   function automatic int hex_weight(input logic [7:0] c);
      if (is_digit(c)) return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // first byte of a token, in idle or right after a number closed
   function automatic void open_token(input logic [7:0] c);
      case (c)
         8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: ;   // whitespace, no token
         "{": emit(KIND_LBRACE, 8'h00, ERR_NONE);
         "}": emit(KIND_RBRACE, 8'h00, ERR_NONE);
         "[": emit(KIND_LBRACKET, 8'h00, ERR_NONE);
         "]": emit(KIND_RBRACKET, 8'h00, ERR_NONE);
         ":": emit(KIND_COLON, 8'h00, ERR_NONE);
         ",": emit(KIND_COMMA, 8'h00, ERR_NONE);
         "\"": begin
            emit(KIND_STRSTART, 8'h00, ERR_NONE);
            lex_mode = MODE_STR;
         end
         "t", "f", "n": begin
            kw_sel = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
            kw_idx = 3'd1;
            lex_mode = MODE_KEY;
         end
         default: begin
            if (c == "-" || is_digit(c)) begin
               num_phase = (c == "-") ? NUM_SIGN : NUM_INT;
               num_digit = is_digit(c);
               lex_mode = MODE_NUM;
               emit(KIND_NUMBYTE, c, ERR_NONE);
            end else begin
               raise_error(ERR_UNEXPECTED);
            end
         end
      endcase
   endfunction

   // advances the number phase; 0 means c closes the number
   function automatic bit number_continues(input logic [7:0] c);
      bit d;
      bit x;
      d = is_digit(c);
      x = (c == "e" || c == "E");
      case (num_phase)
         NUM_SIGN, NUM_INT: begin
            if (d) begin
               num_phase = NUM_INT;
               num_digit = 1'b1;
               return 1'b1;
            end
            if (c == ".") begin
               num_phase = NUM_FRAC;
               return 1'b1;
            end
            if (x) begin
               num_phase = NUM_EXP;
               return 1'b1;
            end
            return 1'b0;
         end
         NUM_FRAC: begin
            if (d) begin
               num_digit = 1'b1;
               return 1'b1;
            end
            if (x) begin
               num_phase = NUM_EXP;
               return 1'b1;
            end
            return 1'b0;
         end
         NUM_EXP: begin
            if (d || c == "+" || c == "-") begin
               num_phase = NUM_EXPDIG;
               return 1'b1;
            end
            return 1'b0;
         end
         default: return d;
      endcase
   endfunction

   // one accepted word through the model; fills step_tok / step_cnt
   function automatic void lex_byte(input logic [7:0] c, input logic eot);
      logic [7:0] v;
      int         w;
      step_cnt = 0;
      if (eot) begin
         // close whatever is open, unless an error already stuck
         if (!err_latched) begin
            case (lex_mode)
               MODE_KEY: emit(KIND_ERROR, 8'h00, ERR_KEYWORD);
               MODE_STR, MODE_ESC: emit(KIND_ERROR, 8'h00, ERR_UNTERM);
               MODE_HEX: emit(KIND_ERROR, 8'h00, ERR_ESC_NUM);
               MODE_NUM: begin
                  if (num_digit) emit(KIND_NUMEND, 8'h00, ERR_NONE);
                  else emit(KIND_ERROR, 8'h00, ERR_ESC_NUM);
               end
               default: ;
            endcase
         end
         emit(KIND_END, 8'h00, ERR_NONE);
         clear_lexer();
      end else if (!err_latched) begin
         case (lex_mode)
            MODE_STR: begin
               if (c == "\"") begin
                  emit(KIND_STREND, 8'h00, ERR_NONE);
                  lex_mode = MODE_IDLE;
               end else if (c == "\\") begin
                  lex_mode = MODE_ESC;
               end else begin
                  emit(KIND_STRBYTE, c, ERR_NONE);
               end
            end
            MODE_ESC: begin
               if (c == "u") begin
                  hex_acc = 16'h0000;
                  hex_cnt = 3'd0;
                  lex_mode = MODE_HEX;
               end else begin
                  // unknown escapes fall through as the byte itself
                  case (c)
                     "b": v = 8'h08;
                     "f": v = 8'h0C;
                     "n": v = 8'h0A;
                     "r": v = 8'h0D;
                     "t": v = 8'h09;
                     default: v = c;
                  endcase
                  emit(KIND_STRBYTE, v, ERR_NONE);
                  lex_mode = MODE_STR;
               end
            end
            MODE_HEX: begin
               w = hex_weight(c);
               if (w < 0) begin
                  raise_error(ERR_ESC_NUM);
               end else begin
                  hex_acc = {hex_acc[11:0], w[3:0]};
                  hex_cnt++;
                  if (hex_cnt == 3'd4) begin
                     emit(KIND_STRBYTE, hex_acc[7:0], ERR_NONE);   // low 8 bits only
                     hex_cnt = 3'd0;
                     lex_mode = MODE_STR;
                  end
               end
            end
            MODE_KEY: begin
               if (int'(kw_idx) >= kw_words[kw_sel].len() || c != kw_words[kw_sel][kw_idx]) begin
                  raise_error(ERR_KEYWORD);
               end else begin
                  kw_idx++;
                  if (int'(kw_idx) >= kw_words[kw_sel].len()) begin
                     emit((kw_sel == KW_TRUE) ? KIND_TRUE :
                          (kw_sel == KW_FALSE) ? KIND_FALSE : KIND_NULL, 8'h00, ERR_NONE);
                     kw_idx = 3'd0;
                     lex_mode = MODE_IDLE;
                  end
               end
            end
            MODE_NUM: begin
               if (number_continues(c)) begin
                  emit(KIND_NUMBYTE, c, ERR_NONE);
               end else begin
                  lex_mode = MODE_IDLE;
                  // digitless number: error, and the closing byte is swallowed
                  if (!num_digit) begin
                     raise_error(ERR_ESC_NUM);
                  end else begin
                     emit(KIND_NUMEND, 8'h00, ERR_NONE);
                     open_token(c);
                  end
               end
            end
            default: begin
               lex_mode = MODE_IDLE;
               open_token(c);
            end
         endcase
      end
   endfunction

   function automatic void queue_tokens();
      pending_type p;
      for (int i = 0; i < step_cnt; i++) begin
         p = '{tok: step_tok[i], last: (i == step_cnt - 1)};
         token_queue = {token_queue, p};
      end
   endfunction

   // ---------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------
   function automatic probe_type derived_row(input logic [7:0] b, input logic e);
      return '{text: b, eot: e, pinned: 1'b0, count: 2'd0, tok0: '0, tok1: '0};
   endfunction

   function automatic probe_type pinned_row(input logic [7:0] b, input logic e, input int n,
                                             input logic [3:0] k0 = KIND_END,
                                             input logic [2:0] r0 = ERR_NONE,
                                             input logic [3:0] k1 = KIND_END,
                                             input logic [2:0] r1 = ERR_NONE);
      return '{text: b, eot: e, pinned: 1'b1, count: 2'(n),
               tok0: '{kind: k0, tbyte: 8'h00, err: r0},
               tok1: '{kind: k1, tbyte: 8'h00, err: r1}};
   endfunction

   probe_type probe_table [30];

   // ---------------------------------------------------------------------
   // Random JSON text
   // ---------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b);
      doc_text = {doc_text, b};
   endfunction

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   function automatic void add_string();
      int         r;
      logic [7:0] c;
      add_byte("\"");
      repeat ($urandom_range(6)) begin
         r = $urandom_range(99);
         if (r < 60) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            add_byte((c == "\"" || c == "\\") ? 8'h61 : c);
         end else if (r < 70) begin
            add_byte(8'($urandom_range(255)));   // raw byte, may break the string
         end else if (r < 85) begin
            add_byte("\\");
            add_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                              : pick_char("\"\\/bfnrt"));
         end else begin
            add_byte("\\");
            add_byte("u");
            repeat (4) begin
               add_byte(($urandom_range(19) == 0) ? pick_char("gxG\"")
                                                  : pick_char("0123456789abcdefABCDEF"));
            end
         end
      end
      add_byte("\"");
   endfunction

   function automatic void add_number();
      if ($urandom_range(99) < 40) add_byte("-");
      repeat (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3))
         add_byte(pick_char("0123456789"));
      if ($urandom_range(99) < 35) begin
         add_byte(".");
         repeat ($urandom_range(3)) add_byte(pick_char("0123456789"));
      end
      if ($urandom_range(99) < 30) begin
         add_byte(pick_char("eE"));
         if ($urandom_range(99) < 50) add_byte(pick_char("+-"));
         repeat ($urandom_range(2)) add_byte(pick_char("0123456789"));
      end
   endfunction

   function automatic void add_keyword();
      string w;
      int    bad;
      w = kw_words[$urandom_range(2)];
      bad = ($urandom_range(9) == 0) ? $urandom_range(1, w.len() - 1) : 0;
      for (int i = 0; i < w.len(); i++) begin
         add_byte((bad != 0 && i == bad) ? 8'($urandom_range(255)) : w[i]);
      end
   endfunction

   // mostly well-formed token runs, some noise, sometimes cut short
   function automatic void build_doc();
      int r;
      doc_text.delete();
      repeat ($urandom_range(1, 12)) begin
         r = $urandom_range(99);
         if (r < 5) add_byte(8'($urandom_range(255)));
         else if (r < 22) add_byte(pick_char("{}[]:,"));
         else if (r < 30) add_byte(WS_CHARS[$urandom_range(5)]);
         else if (r < 55) add_string();
         else if (r < 70) add_keyword();
         else add_number();
         if ($urandom_range(99) < 40) add_byte(WS_CHARS[$urandom_range(5)]);
      end
      // cut the text so end of text lands inside any open token
      if (doc_text.size() != 0 && $urandom_range(99) < 15) begin
         repeat ($urandom_range(doc_text.size() - 1)) void'(doc_text.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one word per call, with random idle cycles ahead of it
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [7:0] b, input logic e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         req_tlast  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic feed_word(input logic [7:0] b, input logic e);
      send_word(b, e);
      live_words++;
      lex_byte(b, e);
      queue_tokens();
   endtask

   // ---------------------------------------------------------------------
   // Result checker and receiver stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (token_queue.size() == 0) begin
            $error("token with nothing expected: kind %0d tdata %h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = token_queue.pop_front();
            if (rsp_tuser !== want.tok.kind) begin
               $error("token_kind: expected %0d, got %0d", want.tok.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.tok.tbyte) begin
               $error("token_byte: expected %h, got %h", want.tok.tbyte, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[10:8] !== want.tok.err) begin
               $error("error_code: expected %0d, got %0d", want.tok.err, rsp_tdata[10:8]);
               fail_count++;
            end
            if (rsp_tdata[15:11] !== 5'd0) begin
               $error("tdata padding: expected 0, got %h", rsp_tdata[15:11]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      probe_type row;
      int        target;

      probe_table = '{
         pinned_row(8'h00, 1'b1, 1, KIND_END),                 // end of text right after reset
         pinned_row("{", 1'b0, 1, KIND_LBRACE),
         pinned_row(":", 1'b0, 1, KIND_COLON),
         pinned_row("]", 1'b0, 1, KIND_RBRACKET),
         pinned_row(8'h0B, 1'b0, 0),                           // VT is whitespace
         derived_row("\"", 1'b0),                              // string: unknown escape, then \u
         derived_row("\\", 1'b0),
         derived_row("q", 1'b0),
         derived_row("\\", 1'b0),
         derived_row("u", 1'b0),
         derived_row("F", 1'b0),
         derived_row("f", 1'b0),
         pinned_row("g", 1'b0, 1, KIND_ERROR, ERR_ESC_NUM),    // non-hex digit in \u
         pinned_row(8'h00, 1'b0, 0),                           // error latched: dropped
         pinned_row(8'hFF, 1'b1, 1, KIND_END),                 // only the end token
         derived_row("-", 1'b0),                               // number with no digit
         derived_row(".", 1'b0),
         pinned_row("x", 1'b0, 1, KIND_ERROR, ERR_ESC_NUM),
         pinned_row(8'h00, 1'b1, 1, KIND_END),
         derived_row("9", 1'b0),                               // exponent with no digits
         derived_row("e", 1'b0),
         derived_row("}", 1'b0),                               // numend, then the brace
         derived_row("n", 1'b0),                               // broken keyword
         derived_row("u", 1'b0),
         pinned_row("\"", 1'b0, 1, KIND_ERROR, ERR_KEYWORD),
         pinned_row(8'h00, 1'b1, 1, KIND_END),
         pinned_row(8'hFF, 1'b0, 1, KIND_ERROR, ERR_UNEXPECTED),
         pinned_row(8'h00, 1'b1, 1, KIND_END),
         derived_row("\"", 1'b0),                              // string left open at end
         derived_row(8'h80, 1'b0)
      };

      send_idle_pct = 18;
      recv_idle_pct = 46;
      repeat (HOLD_RESET) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_table[i]) begin
         row = probe_table[i];
         send_word(row.text, row.eot);
         lex_byte(row.text, row.eot);
         if (row.pinned) begin
            step_cnt    = row.count;
            step_tok[0] = row.tok0;
            step_tok[1] = row.tok1;
         end
         queue_tokens();
      end
      // close the open string: unterminated string error, then the end token
      send_word(8'h00, 1'b1);
      lex_byte(8'h00, 1'b1);
      step_cnt    = 2;
      step_tok[0] = '{kind: KIND_ERROR, tbyte: 8'h00, err: ERR_UNTERM};
      step_tok[1] = '{kind: KIND_END, tbyte: 8'h00, err: ERR_NONE};
      queue_tokens();

      // random text in three idling phases: sender light, receiver light, none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
         recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
         target = live_words + WORDS_PHASE;
         while (live_words < target) begin
            build_doc();
            foreach (doc_text[i]) feed_word(doc_text[i], 1'b0);
            feed_word(8'($urandom_range(255)), 1'b1);
         end
      end

      req_tvalid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("json_byte_tokenizer verification clean");
      end else begin
         $display("json_byte_tokenizer verification failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("json_byte_tokenizer verification failed");
      $finish;
   end

endmodule
